// ----- src/epoch_seconds_to_calendar_core_defines.svh -----
// Assertion helpers for the calendar core.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, live through reset.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/esc_pkg.sv -----
package esc_pkg;

  // Fixed calendar constants
  localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
  localparam logic [10:0] DAYS_PER_GROUP = 11'd1461;
  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [10:0] YEAR_DAYS      = 11'd365;
  localparam logic [10:0] LEAP_DAYS      = 11'd366;
  localparam logic [2:0]  EPOCH_WDAY     = 3'd4;   // 1970-01-01 was a Thursday
  localparam logic [5:0]  SIXTY          = 6'd60;

  // Word flows through input reg, two split stages, one decode stage, result reg
  localparam int PIPE_STAGES = 5;

  // Exact reciprocals: m = ceil(2^(N+l)/d) is exact for any x < 2^N
  // days = (t >> 7) / 675
  localparam int          DAY_SHIFT  = 35;
  localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
  // four-year groups = (t >> 7) / 986175
  localparam int          GRP_SHIFT  = 45;
  localparam logic [25:0] GRP_RECIP  =
    26'(((64'd1 << GRP_SHIFT) + 64'd986174) / 64'd986175);
  // weeks = (days + 4) / 7
  localparam int          WEEK_SHIFT = 19;
  localparam logic [16:0] WEEK_RECIP = 17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
  // hours = (sod >> 4) / 225
  localparam int          HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_RECIP = 14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);
  // total minutes = (sod >> 2) / 15
  localparam int          MIN_SHIFT  = 19;
  localparam logic [15:0] MIN_RECIP  = 16'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

  // Split of the day count, handed from the splitter to both decoders
  typedef struct packed {
    logic [16:0] sod;         // seconds of day
    logic [10:0] day_in_grp;  // day within four-year group
    logic [5:0]  grp;         // four-year group index
    logic [12:0] wq;          // (days + 4) / 7
    logic [2:0]  dow_low;     // low bits of days + 4
  } esc_split_t;

  // First day-of-year of each month, 0 is January
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && idx >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ----- src/esc_day_split.sv -----
module esc_day_split import esc_pkg::*; (
  input  logic       clk,
  input  logic [31:0] t_in,
  output esc_split_t split
);

  // stage 1: days and four-year groups straight from the timestamp
  logic [50:0] day_prod;
  logic [50:0] grp_prod;
  logic [15:0] days;
  logic [5:0]  grp;
  logic [16:0] t_low;

  assign day_prod = 51'(t_in[31:7]) * 51'(DAY_RECIP);
  assign grp_prod = 51'(t_in[31:7]) * 51'(GRP_RECIP);

  always_ff @(posedge clk) begin
    days  <= day_prod[50:DAY_SHIFT];
    grp   <= grp_prod[50:GRP_SHIFT];
    t_low <= t_in[16:0];
  end

  // stage 2: remainders and week quotient
  logic [32:0] day_secs;
  logic [16:0] grp_days;
  logic [15:0] days4;
  logic [32:0] week_prod;

  assign day_secs  = 33'(days) * 33'(SEC_PER_DAY);
  assign grp_days  = 17'(grp) * 17'(DAYS_PER_GROUP);
  assign days4     = days + 16'(EPOCH_WDAY);
  assign week_prod = 33'(days4) * 33'(WEEK_RECIP);

  always_ff @(posedge clk) begin
    split.sod        <= t_low - day_secs[16:0];
    split.day_in_grp <= days[10:0] - grp_days[10:0];
    split.grp        <= grp;
    split.wq         <= week_prod[31:WEEK_SHIFT];
    split.dow_low    <= days4[2:0];
  end

endmodule

// ----- src/esc_time_of_day.sv -----
module esc_time_of_day import esc_pkg::*; (
  input  logic       clk,
  input  esc_split_t split,
  output logic [5:0] second,
  output logic [5:0] minute,
  output logic [4:0] hour
);

  // stage 3: hour and total minutes, both from seconds of day
  logic [26:0] hour_prod;
  logic [30:0] min_prod;
  logic [16:0] sod;
  logic [10:0] mtot;
  logic [4:0]  hr;

  assign hour_prod = 27'(split.sod[16:4]) * 27'(HOUR_RECIP);
  assign min_prod  = 31'(split.sod[16:2]) * 31'(MIN_RECIP);

  always_ff @(posedge clk) begin
    sod  <= split.sod;
    mtot <= min_prod[29:MIN_SHIFT];
    hr   <= hour_prod[25:HOUR_SHIFT];
  end

  // stage 4: remainders into the result register
  logic [16:0] mt60;
  logic [10:0] h60;

  assign mt60 = 17'(mtot) * 17'(SIXTY);
  assign h60  = 11'(hr) * 11'(SIXTY);

  always_ff @(posedge clk) begin
    second <= sod[5:0] - mt60[5:0];
    minute <= mtot[5:0] - h60[5:0];
    hour   <= hr;
  end

endmodule

// ----- src/esc_date.sv -----
module esc_date import esc_pkg::*; (
  input  logic        clk,
  input  esc_split_t  split,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month,
  output logic [11:0] year,
  output logic [2:0]  weekday,
  output logic        leap_flag
);

  // stage 3: year within group, day of year, weekday
  logic [1:0]  yoff;
  logic [8:0]  doy_next;
  logic        leap_next;
  logic [15:0] wq7;
  logic [10:0] d;

  assign d   = split.day_in_grp;
  assign wq7 = 16'(split.wq) * 16'd7;

  always_comb begin
    priority if (d < YEAR_DAYS) begin
      yoff      = 2'd0;
      doy_next  = d[8:0];
      leap_next = 1'b0;
    end else if (d < 11'(YEAR_DAYS + YEAR_DAYS)) begin
      yoff      = 2'd1;
      doy_next  = 9'(d - YEAR_DAYS);
      leap_next = 1'b0;
    end else if (d < 11'(YEAR_DAYS + YEAR_DAYS + LEAP_DAYS)) begin
      yoff      = 2'd2;
      doy_next  = 9'(d - 11'(YEAR_DAYS + YEAR_DAYS));
      leap_next = 1'b1;
    end else begin
      yoff      = 2'd3;
      doy_next  = 9'(d - 11'(YEAR_DAYS + YEAR_DAYS + LEAP_DAYS));
      leap_next = 1'b0;
    end
  end

  logic [8:0]  doy;
  logic        leap;
  logic [11:0] yr;
  logic [2:0]  wd;

  always_ff @(posedge clk) begin
    doy  <= doy_next;
    leap <= leap_next;
    yr   <= EPOCH_YEAR + 12'({split.grp, 2'b00}) + 12'(yoff);
    wd   <= split.dow_low - wq7[2:0];
  end

  // stage 4: month by start-of-month compare
  logic [3:0] mon_idx;
  logic [8:0] mday_off;

  always_comb begin
    mon_idx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy >= month_start(leap, 4'(i))) begin
        mon_idx = 4'(i);
      end
    end
  end

  assign mday_off = doy - month_start(leap, mon_idx);

  always_ff @(posedge clk) begin
    day_of_month <= 5'(mday_off) + 5'd1;
    month        <= mon_idx + 4'd1;
    year         <= yr;
    weekday      <= wd;
    leap_flag    <= leap;
  end

endmodule

// ----- src/epoch_seconds_to_calendar_core.sv -----
// Channel   Ports                                          Handshake
// -------   ---------------------------------------------  -------------------------
// input     epoch_seconds                                  start & !busy at clk edge
// result    second minute hour day_of_month month year     done, one cycle, no stall
//           weekday leap_flag
//
// One word enters per clock while busy is low; each passes through the input
// register, two day-split stages, one decode stage and the result register.
// Constant divides are reciprocal multiplies, none over 25x26 bits.
// busy is high only during reset and the cycle after it.
// rst clears the valid chain; payload registers carry no reset.
// The receiver cannot stall: done marks each result for exactly one cycle.

`include "epoch_seconds_to_calendar_core_defines.svh"

module epoch_seconds_to_calendar_core import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month,
  output logic [11:0] year,
  output logic [2:0]  weekday,
  output logic        leap_flag
);

  logic                   accept;
  logic [31:0]            t_in;      // input register
  logic [PIPE_STAGES-1:0] vld;       // one valid per stage, top bit is done
  esc_split_t             split;

  assign accept = start && !busy;
  assign done   = vld[PIPE_STAGES-1];

  // busy only guards the reset window
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[PIPE_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_in <= epoch_seconds;
    end
  end

  // days, seconds of day, day in four-year group, week quotient
  esc_day_split u_split (
    .clk   (clk),
    .t_in  (t_in),
    .split (split)
  );

  // hh:mm:ss
  esc_time_of_day u_time (
    .clk    (clk),
    .split  (split),
    .second (second),
    .minute (minute),
    .hour   (hour)
  );

  // year, month, day, weekday, leap
  esc_date u_date (
    .clk          (clk),
    .split        (split),
    .day_of_month (day_of_month),
    .month        (month),
    .year         (year),
    .weekday      (weekday),
    .leap_flag    (leap_flag)
  );

  // every result traces back to an accepted start
  `ESC_ASSERT_IMP(a_done_latency, done, $past(start && !busy, PIPE_STAGES), "done without start")
  // every fourth year from 1972 is taken as leap, and no other
  `ESC_ASSERT_IMP(a_leap_year, done, leap_flag == (year[1:0] == 2'b00), "leap flag mismatch")
  `ESC_ASSERT_IMP(a_time_range, done, hour < 5'd24 && minute < 6'd60 && second < 6'd60, "time range")
  // reset empties the pipe and blocks input
  `ESC_ASSERT_NEXT(a_reset_flush, rst, !done && busy, "reset did not flush")

endmodule
